>>> hw/rtl/gqk_pkg.sv
// Shared types and constants for the goal queue with kill by identifier.
// Used by gqk_cell, gqk_ctrl and goal_queue_with_kill_by_id; depends on nothing.
package gqk_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int FUNC_W    = 3;
    localparam int TYPE_W    = 4;
    localparam int ID_W      = 16;
    localparam int WORD_W    = 64;

    // Command codes carried on the func field.
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH    = 3'd0,
        FN_ADVANCE = 3'd1,
        FN_KILL    = 3'd2,
        FN_CLEAR   = 3'd3,
        FN_MARK    = 3'd4,
        FN_PAUSE   = 3'd5,
        FN_RESUME  = 3'd6,
        FN_PEEK    = 3'd7
    } func_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_SHIFT,
        CELL_SET_REACHED,
        CELL_SET_PAUSED,
        CELL_CLR_PAUSED
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KILL,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0] goal_type;
        logic [ID_W-1:0]   goal_id;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic              reached;
        logic              paused;
    } entry_t;

endpackage

>>> hw/rtl/gqk_cell.sv
// One slot of the goal chain: holds an entry and loads from its right neighbor on a shift.
// Depends on gqk_pkg.
module gqk_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic                   clk,
    input  gqk_pkg::cell_op_t      op,
    input  logic [IDX_W-1:0]       pos,
    input  gqk_pkg::entry_t        push_entry,
    input  gqk_pkg::entry_t        next_entry,
    input  logic [gqk_pkg::ID_W-1:0] kill_id,
    output gqk_pkg::entry_t        entry,
    output logic                   match
);
    import gqk_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;
    logic   at_or_after;

    assign hit         = (pos == IDX_W'(INDEX));
    assign at_or_after = (IDX_W'(INDEX) >= pos);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            CELL_HOLD:
            begin
            end
            CELL_PUSH:
            begin
                if (hit)
                begin
                    entry_next = push_entry;
                end
            end
            CELL_SHIFT:
            begin
                // Every cell from the removed slot onward takes its neighbor's entry.
                if (at_or_after)
                begin
                    entry_next = next_entry;
                end
            end
            CELL_SET_REACHED:
            begin
                if (hit)
                begin
                    entry_next.reached = 1'b1;
                end
            end
            CELL_SET_PAUSED:
            begin
                if (hit)
                begin
                    entry_next.paused = 1'b1;
                end
            end
            CELL_CLR_PAUSED:
            begin
                if (hit)
                begin
                    entry_next.paused = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg.goal_id == kill_id);

endmodule

>>> hw/rtl/gqk_ctrl.sv
// Command sequencer: occupancy count, kill scan pointer, cell operations and result register.
// Depends on gqk_pkg.
module gqk_ctrl #(
    parameter int DEPTH = gqk_pkg::DEPTH_DEF,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [gqk_pkg::FUNC_W-1:0] func,
    input  logic [gqk_pkg::ID_W-1:0]   goal_id,
    input  gqk_pkg::entry_t            head_entry,
    input  logic [DEPTH-1:0]           match_vec,
    output gqk_pkg::cell_op_t          cell_op,
    output logic [IDX_W-1:0]           cell_pos,
    output logic [gqk_pkg::ID_W-1:0]   kill_id,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       status,
    output logic                       head_valid,
    output gqk_pkg::entry_t            head_out,
    output logic [CNT_W-1:0]           remaining
);
    import gqk_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [ID_W-1:0]  kill_id_reg, kill_id_next;
    logic             status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_status_reg;
    logic             out_head_valid_reg;
    entry_t           out_head_reg;
    logic [CNT_W-1:0] out_remaining_reg;
    logic             load_out;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kill_id_reg <= kill_id_next;
        status_reg  <= status_next;
        if (load_out)
        begin
            out_status_reg     <= status_reg;
            out_head_valid_reg <= (occ_reg != '0);
            out_head_reg       <= (occ_reg != '0) ? head_entry : '0;
            out_remaining_reg  <= occ_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        ptr_next     = ptr_reg;
        kill_id_next = kill_id_reg;
        status_next  = status_reg;
        cell_op      = CELL_HOLD;
        cell_pos     = '0;
        load_out     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = 1'b0;
                    state_next  = ST_REPORT;
                    unique case (func)
                        FN_PUSH:
                        begin
                            if (occ_reg == CNT_W'(DEPTH))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                cell_op  = CELL_PUSH;
                                cell_pos = occ_reg[IDX_W-1:0];
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        FN_ADVANCE:
                        begin
                            if (occ_reg != '0)
                            begin
                                cell_op  = CELL_SHIFT;
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        FN_KILL:
                        begin
                            kill_id_next = goal_id;
                            ptr_next     = '0;
                            state_next   = ST_KILL;
                        end
                        FN_CLEAR:
                        begin
                            occ_next = '0;
                        end
                        FN_MARK:
                        begin
                            if (occ_reg != '0)
                            begin
                                cell_op = CELL_SET_REACHED;
                            end
                        end
                        FN_PAUSE:
                        begin
                            if (occ_reg != '0)
                            begin
                                cell_op = CELL_SET_PAUSED;
                            end
                        end
                        FN_RESUME:
                        begin
                            if (occ_reg != '0)
                            begin
                                cell_op = CELL_CLR_PAUSED;
                            end
                        end
                        FN_PEEK:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_KILL:
            begin
                // The pointer stays put after a removal, since the next entry moves into it.
                if (ptr_reg < occ_reg)
                begin
                    if (match_vec[ptr_reg[IDX_W-1:0]])
                    begin
                        cell_op  = CELL_SHIFT;
                        cell_pos = ptr_reg[IDX_W-1:0];
                        occ_next = occ_reg - CNT_W'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign kill_id    = kill_id_reg;
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign head_valid = out_head_valid_reg;
    assign head_out   = out_head_reg;
    assign remaining  = out_remaining_reg;

endmodule

>>> hw/rtl/goal_queue_with_kill_by_id.sv
// Goal queue with kill by identifier: a row of DEPTH slot cells with the head in cell 0.
// Sequencing: push, advance, clear, mark, pause, resume and peek go from acceptance to ST_REPORT,
// where the result beat is registered; kill scans one slot per cycle in ST_KILL before ST_REPORT.
// A new command is taken only in ST_IDLE, after the last one's result is loaded; a held result stalls input.
// Reset: rst_n clears the count, the sequencer and the result valid; slot contents are not reset.
// Depends on gqk_pkg, gqk_cell and gqk_ctrl.
module goal_queue_with_kill_by_id #(
    parameter int DEPTH = gqk_pkg::DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [gqk_pkg::FUNC_W-1:0]   func,
    input  logic [gqk_pkg::ID_W-1:0]     goal_id,
    input  logic [gqk_pkg::TYPE_W-1:0]   goal_type,
    input  logic [gqk_pkg::WORD_W-1:0]   word_a,
    input  logic [gqk_pkg::WORD_W-1:0]   word_b,
    input  logic [gqk_pkg::WORD_W-1:0]   word_c,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic                         head_valid,
    output logic [gqk_pkg::TYPE_W-1:0]   head_type,
    output logic [gqk_pkg::ID_W-1:0]     head_id,
    output logic [gqk_pkg::WORD_W-1:0]   head_word_a,
    output logic [gqk_pkg::WORD_W-1:0]   head_word_b,
    output logic [gqk_pkg::WORD_W-1:0]   head_word_c,
    output logic                         head_reached,
    output logic                         head_paused,
    output logic [CNT_W-1:0]             remaining
);
    import gqk_pkg::*;

    entry_t           push_entry;
    entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0] match_vec;
    cell_op_t         cell_op;
    logic [IDX_W-1:0] cell_pos;
    logic [ID_W-1:0]  kill_id;
    entry_t           head_out;

    always_comb
    begin
        push_entry.goal_type = goal_type;
        push_entry.goal_id   = goal_id;
        push_entry.word_a    = word_a;
        push_entry.word_b    = word_b;
        push_entry.word_c    = word_c;
        push_entry.reached   = 1'b0;
        push_entry.paused    = 1'b0;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        entry_t next_entry;

        // The last cell has no neighbor and simply keeps its own entry on a shift.
        if (g == DEPTH - 1)
        begin : g_last
            assign next_entry = cell_entry[g];
        end
        else
        begin : g_mid
            assign next_entry = cell_entry[g+1];
        end

        gqk_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .pos        (cell_pos),
            .push_entry (push_entry),
            .next_entry (next_entry),
            .kill_id    (kill_id),
            .entry      (cell_entry[g]),
            .match      (match_vec[g])
        );
    end

    gqk_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .goal_id    (goal_id),
        .head_entry (cell_entry[0]),
        .match_vec  (match_vec),
        .cell_op    (cell_op),
        .cell_pos   (cell_pos),
        .kill_id    (kill_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .head_valid (head_valid),
        .head_out   (head_out),
        .remaining  (remaining)
    );

    assign head_type    = head_out.goal_type;
    assign head_id      = head_out.goal_id;
    assign head_word_a  = head_out.word_a;
    assign head_word_b  = head_out.word_b;
    assign head_word_c  = head_out.word_c;
    assign head_reached = head_out.reached;
    assign head_paused  = head_out.paused;

endmodule
